/* rtl/core/hsr_pkg.sv */
// Shared types, constants and fixed-point helpers for the HJB stencil relaxation update.
`timescale 1ns / 1ps

package hsr_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int VOL_W = 22;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t WMAX = 32'sh7FFFFFFF;
    localparam word_t WMIN = 32'sh80000000;
    localparam word_t FX_HALF = 32'sd32768;
    localparam word_t FX_ONE = 32'sd65536;
    localparam word_t FX_TEN = 32'sd655360;
    localparam word_t FX_FIFTY = 32'sd3276800;
    localparam word_t FX_SIXTYFOUR = 32'sd4194304;

    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic [63:0] EXP_RECIP = ((64'd1 << 54) + (LN2_Q30 >> 1)) / LN2_Q30;
    localparam int EXP_TERMS = 12;
    localparam int EXP_LAT = 3 + 3 * EXP_TERMS + 1;
    localparam int PIPE_LAT = 5 + EXP_LAT + 7;

    localparam logic [CFG_IDX_W-1:0] REG_RELAX_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISK_AVERSION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PRICE_STEP_SQ = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VOL_STEP_SQ = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_VOLVOL_SQ = 3'd7;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_here;
        logic signed [WORD_W-1:0] value_price_up;
        logic signed [WORD_W-1:0] value_price_down;
        logic signed [WORD_W-1:0] value_vol_up;
        logic signed [WORD_W-1:0] value_vol_down;
        logic signed [WORD_W-1:0] value_inv_up;
        logic signed [WORD_W-1:0] value_inv_down;
        logic [VOL_W-1:0]         vol_level;
    } hsr_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_value;
        logic [WORD_W-2:0]        abs_change;
    } hsr_result_t;

    function automatic logic signed [35:0] sx36(input word_t a);
        sx36 = {{4{a[WORD_W-1]}}, a};
    endfunction

    function automatic word_t sat36(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            sat36 = WMAX;
        else if (v < -36'sd2147483648)
            sat36 = WMIN;
        else
            sat36 = v[WORD_W-1:0];
    endfunction

    function automatic word_t negs(input word_t a);
        negs = sat36(36'sd0 - sx36(a));
    endfunction

    // Product rounded half away from zero on the magnitude, then saturated.
    function automatic word_t mulq(input word_t a, input word_t b);
        logic        neg;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] lim;
        neg = a[WORD_W-1] ^ b[WORD_W-1];
        ua = a[WORD_W-1] ? 32'(-a) : 32'(a);
        ub = b[WORD_W-1] ? 32'(-b) : 32'(b);
        p = {32'd0, ua} * {32'd0, ub};
        q = (p + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
        lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
        if (q > lim)
            q = lim;
        mulq = neg ? word_t'(32'd0 - q[31:0]) : word_t'(q[31:0]);
    endfunction

    function automatic word_t second_diff(input word_t up, input word_t here, input word_t down);
        second_diff = sat36(sx36(up) + sx36(down) - sx36(here) - sx36(here));
    endfunction

endpackage

/* rtl/core/hsr_exp.sv */
// Pipelined fixed-point exponential: range reduction, twelve Taylor terms, final scaling.
`timescale 1ns / 1ps

module hsr_exp (
    input  logic          clk,
    input  logic          en,
    input  hsr_pkg::word_t arg,
    output hsr_pkg::word_t value
);
    import hsr_pkg::*;

    localparam logic signed [26:0] RECIP_S = 27'(EXP_RECIP);
    localparam logic signed [38:0] LN2_S = 39'(LN2_Q30);

    typedef struct packed {
        logic signed [37:0] xg;
        logic signed [7:0]  n0;
    } red0_t;

    typedef struct packed {
        logic signed [38:0] r0;
        logic signed [7:0]  n0;
    } red1_t;

    typedef struct packed {
        logic [30:0]       term;
        logic [31:0]       sum;
        logic [29:0]       r;
        logic signed [7:0] n;
    } tay_t;

    typedef struct packed {
        logic [30:0]       v;
        logic [31:0]       sum;
        logic [29:0]       r;
        logic signed [7:0] n;
    } tmul_t;

    typedef struct packed {
        logic [30:0]       q0;
        logic [30:0]       v;
        logic [31:0]       sum;
        logic [29:0]       r;
        logic signed [7:0] n;
    } tdiv_t;

    red0_t red0_reg, red0_next;
    red1_t red1_reg, red1_next;
    tay_t  tay_reg [0:EXP_TERMS];
    tay_t  tay0_next;
    word_t value_reg, value_next;

    logic signed [23:0] xc;
    logic signed [50:0] prod;

    always_comb
    begin
        if (arg > FX_SIXTYFOUR)
            xc = 24'(FX_SIXTYFOUR);
        else if (arg < -FX_SIXTYFOUR)
            xc = 24'(-FX_SIXTYFOUR);
        else
            xc = arg[23:0];
        prod = xc * RECIP_S;
        red0_next.xg = {xc, 14'd0};
        red0_next.n0 = prod[47:40];
    end

    always_comb
    begin
        red1_next.n0 = red0_reg.n0;
        red1_next.r0 = 39'(red0_reg.xg) - 39'(red0_reg.n0) * LN2_S;
    end

    always_comb
    begin
        tay0_next.term = 31'd1 << 30;
        tay0_next.sum = 32'd1 << 30;
        if (red1_reg.r0 < 39'sd0)
        begin
            tay0_next.n = red1_reg.n0 - 8'sd1;
            tay0_next.r = 30'(red1_reg.r0 + LN2_S);
        end
        else if (red1_reg.r0 >= LN2_S)
        begin
            tay0_next.n = red1_reg.n0 + 8'sd1;
            tay0_next.r = 30'(red1_reg.r0 - LN2_S);
        end
        else
        begin
            tay0_next.n = red1_reg.n0;
            tay0_next.r = red1_reg.r0[29:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red0_reg <= red0_next;
            red1_reg <= red1_next;
            tay_reg[0] <= tay0_next;
            value_reg <= value_next;
        end
    end

    for (genvar g = 1; g <= EXP_TERMS; g++)
    begin : g_term
        localparam logic [32:0] RECIP_I = 33'((64'd1 << 32) / g);
        localparam logic [34:0] DIV_I = 35'(g);

        tmul_t tmul_reg, tmul_next;
        tdiv_t tdiv_reg, tdiv_next;
        tay_t  tay_next;
        logic [60:0] p_tr;
        logic [63:0] p_rc;
        logic [34:0] rem;

        always_comb
        begin
            p_tr = 61'(tay_reg[g-1].term) * 61'(tay_reg[g-1].r);
            tmul_next.v = p_tr[60:30];
            tmul_next.sum = tay_reg[g-1].sum;
            tmul_next.r = tay_reg[g-1].r;
            tmul_next.n = tay_reg[g-1].n;
        end

        always_comb
        begin
            p_rc = 64'(tmul_reg.v) * 64'(RECIP_I);
            tdiv_next.q0 = p_rc[62:32];
            tdiv_next.v = tmul_reg.v;
            tdiv_next.sum = tmul_reg.sum;
            tdiv_next.r = tmul_reg.r;
            tdiv_next.n = tmul_reg.n;
        end

        always_comb
        begin
            rem = 35'(tdiv_reg.v) - 35'(tdiv_reg.q0) * DIV_I;
            tay_next.term = (rem >= DIV_I) ? tdiv_reg.q0 + 31'd1 : tdiv_reg.q0;
            tay_next.sum = tdiv_reg.sum + 32'(tay_next.term);
            tay_next.r = tdiv_reg.r;
            tay_next.n = tdiv_reg.n;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tmul_reg <= tmul_next;
                tdiv_reg <= tdiv_next;
                tay_reg[g] <= tay_next;
            end
        end
    end

    logic signed [8:0] sh;
    logic [5:0]        rsh;
    logic [63:0]       scaled;

    always_comb
    begin
        sh = 9'(tay_reg[EXP_TERMS].n) - 9'sd14;
        rsh = 6'(-sh);
        scaled = 64'd0;
        if (sh >= 9'sd33)
            value_next = WMAX;
        else if (sh >= 9'sd0)
        begin
            scaled = {32'd0, tay_reg[EXP_TERMS].sum} << sh[5:0];
            value_next = (scaled > 64'h7FFFFFFF) ? WMAX : word_t'(scaled[31:0]);
        end
        else if (sh < -9'sd40)
            value_next = 32'sd0;
        else
        begin
            scaled = ({32'd0, tay_reg[EXP_TERMS].sum} + (64'd1 << (rsh - 6'd1))) >> rsh;
            value_next = word_t'(scaled[31:0]);
        end
    end

    assign value = value_reg;

endmodule

/* rtl/core/hjb_stencil_relax_update.sv */
// Top level of the HJB stencil relaxation update: configuration, datapath pipeline, handshakes.
`timescale 1ns / 1ps

//  channel   signals                                   direction
//  item      item_valid, item_stall, item              in (stall out)
//  result    result_valid, result_stall, result        out (stall in)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
//
// One item per clock is taken while no stall is raised; each result passes through s1-s5, the
// exponential pipelines (40 stages each), x1-x6 and the result register, a depth set mostly by the exponentials.
// Reset clears the valid bits and loads the register defaults.
// A stall on the result side while a result is waiting freezes the whole pipeline and raises item_stall.

module hjb_stencil_relax_update (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  hsr_pkg::hsr_item_t                     item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output hsr_pkg::hsr_result_t                   result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hsr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [hsr_pkg::WORD_W-1:0]             cfg_data
);
    import hsr_pkg::*;

    typedef struct packed {
        word_t here; word_t sdp; word_t sdv; word_t dplus; word_t dminus; word_t sig2;
    } s1_t;
    typedef struct packed {
        word_t here; word_t dplus; word_t dminus; word_t db; word_t da;
        word_t hs; word_t tp; word_t tv;
    } s2_t;
    typedef struct packed {
        word_t here; word_t kb; word_t ka; word_t gb; word_t ga; word_t diff; word_t vol;
    } s3_t;
    typedef struct packed {
        word_t here; word_t a1b; word_t a1a; word_t mgb; word_t mga; word_t diff; word_t vol;
    } s4_t;
    typedef struct packed {
        word_t here; word_t a1b; word_t a1a; word_t a2b; word_t a2a; word_t diff; word_t vol;
    } s5_t;
    typedef struct packed {
        word_t here; word_t diff; word_t vol;
    } side_t;
    typedef struct packed {
        word_t here; word_t diff; word_t vol; word_t lb; word_t la; word_t eb; word_t ea;
    } x1_t;
    typedef struct packed {
        word_t here; word_t diff; word_t vol; word_t jb; word_t ja;
    } x2_t;
    typedef struct packed {
        word_t here; word_t val;
    } pair_t;

    logic [16:0] relax_gain_reg;
    logic [30:0] risk_aversion_reg;
    logic [30:0] decay_rate_reg;
    logic [30:0] arrival_scale_reg;
    word_t       spread_offset_reg;
    logic [30:0] inv_price_step_sq_reg;
    logic [30:0] inv_vol_step_sq_reg;
    logic [30:0] half_volvol_sq_reg;

    word_t gam, kk, aa, rg;

    logic                en;
    logic [PIPE_LAT-1:0] vld_reg;

    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    s4_t   s4_reg, s4_next;
    s5_t   s5_reg, s5_next;
    side_t side_reg [EXP_LAT];
    x1_t   x1_reg, x1_next;
    x2_t   x2_reg, x2_next;
    pair_t x3_reg, x3_next;
    pair_t x4_reg, x4_next;
    pair_t x5_reg, x5_next;
    pair_t x6_reg, x6_next;
    hsr_result_t result_reg, result_next;

    word_t e1b, e1a, e2b, e2a;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_gain_reg <= 17'd32768;
            risk_aversion_reg <= 31'd6554;
            decay_rate_reg <= 31'd98304;
            arrival_scale_reg <= 31'd65536;
            spread_offset_reg <= 32'sd42297;
            inv_price_step_sq_reg <= 31'd393380;
            inv_vol_step_sq_reg <= 31'd68044168;
            half_volvol_sq_reg <= 31'd328;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RELAX_GAIN:        relax_gain_reg <= cfg_data[16:0];
                REG_RISK_AVERSION:     risk_aversion_reg <= cfg_data[30:0];
                REG_DECAY_RATE:        decay_rate_reg <= cfg_data[30:0];
                REG_ARRIVAL_SCALE:     arrival_scale_reg <= cfg_data[30:0];
                REG_SPREAD_OFFSET:     spread_offset_reg <= word_t'(cfg_data);
                REG_INV_PRICE_STEP_SQ: inv_price_step_sq_reg <= cfg_data[30:0];
                REG_INV_VOL_STEP_SQ:   inv_vol_step_sq_reg <= cfg_data[30:0];
                REG_HALF_VOLVOL_SQ:    half_volvol_sq_reg <= cfg_data[30:0];
                default:               relax_gain_reg <= relax_gain_reg;
            endcase
        end
    end

    assign gam = word_t'({1'b0, risk_aversion_reg});
    assign kk = word_t'({1'b0, decay_rate_reg});
    assign aa = word_t'({1'b0, arrival_scale_reg});
    assign rg = word_t'({15'd0, relax_gain_reg});

    assign en = !vld_reg[PIPE_LAT-1] || !result_stall;
    assign item_stall = !en;
    assign result_valid = vld_reg[PIPE_LAT-1];
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], item_valid};
    end

    always_comb
    begin
        s1_next.here = item.value_here;
        s1_next.sdp = second_diff(item.value_price_up, item.value_here, item.value_price_down);
        s1_next.sdv = second_diff(item.value_vol_up, item.value_here, item.value_vol_down);
        s1_next.dplus = sat36(sx36(item.value_inv_up) - sx36(item.value_here));
        s1_next.dminus = sat36(sx36(item.value_here) - sx36(item.value_inv_down));
        s1_next.sig2 = mulq(word_t'({10'd0, item.vol_level}), word_t'({10'd0, item.vol_level}));
    end

    always_comb
    begin
        s2_next.here = s1_reg.here;
        s2_next.dplus = s1_reg.dplus;
        s2_next.dminus = s1_reg.dminus;
        s2_next.db = sat36(sx36(spread_offset_reg) + sx36(s1_reg.dplus));
        if (s2_next.db > FX_TEN)
            s2_next.db = FX_TEN;
        s2_next.da = sat36(sx36(spread_offset_reg) - sx36(s1_reg.dminus));
        if (s2_next.da > FX_TEN)
            s2_next.da = FX_TEN;
        s2_next.hs = mulq(s1_reg.sig2, FX_HALF);
        s2_next.tp = mulq(s1_reg.sdp, word_t'({1'b0, inv_price_step_sq_reg}));
        s2_next.tv = mulq(s1_reg.sdv, word_t'({1'b0, inv_vol_step_sq_reg}));
    end

    always_comb
    begin
        s3_next.here = s2_reg.here;
        s3_next.kb = mulq(kk, s2_reg.db);
        s3_next.ka = mulq(kk, s2_reg.da);
        s3_next.gb = sat36(sx36(s2_reg.db) + sx36(s2_reg.dplus));
        s3_next.ga = sat36(sx36(s2_reg.da) - sx36(s2_reg.dminus));
        s3_next.diff = mulq(s2_reg.hs, s2_reg.tp);
        s3_next.vol = mulq(word_t'({1'b0, half_volvol_sq_reg}), s2_reg.tv);
    end

    always_comb
    begin
        s4_next.here = s3_reg.here;
        s4_next.a1b = negs(s3_reg.kb);
        s4_next.a1a = negs(s3_reg.ka);
        s4_next.mgb = mulq(gam, s3_reg.gb);
        s4_next.mga = mulq(gam, s3_reg.ga);
        s4_next.diff = s3_reg.diff;
        s4_next.vol = s3_reg.vol;
    end

    always_comb
    begin
        s5_next.here = s4_reg.here;
        s5_next.a1b = s4_reg.a1b;
        s5_next.a1a = s4_reg.a1a;
        s5_next.a2b = negs(s4_reg.mgb);
        if (s5_next.a2b > FX_FIFTY)
            s5_next.a2b = FX_FIFTY;
        if (s5_next.a2b < -FX_FIFTY)
            s5_next.a2b = -FX_FIFTY;
        s5_next.a2a = negs(s4_reg.mga);
        if (s5_next.a2a > FX_FIFTY)
            s5_next.a2a = FX_FIFTY;
        if (s5_next.a2a < -FX_FIFTY)
            s5_next.a2a = -FX_FIFTY;
        s5_next.diff = s4_reg.diff;
        s5_next.vol = s4_reg.vol;
    end

    hsr_exp u_exp_lb (.clk(clk), .en(en), .arg(s5_reg.a1b), .value(e1b));
    hsr_exp u_exp_la (.clk(clk), .en(en), .arg(s5_reg.a1a), .value(e1a));
    hsr_exp u_exp_jb (.clk(clk), .en(en), .arg(s5_reg.a2b), .value(e2b));
    hsr_exp u_exp_ja (.clk(clk), .en(en), .arg(s5_reg.a2a), .value(e2a));

    always_comb
    begin
        x1_next.here = side_reg[EXP_LAT-1].here;
        x1_next.diff = side_reg[EXP_LAT-1].diff;
        x1_next.vol = side_reg[EXP_LAT-1].vol;
        x1_next.lb = mulq(aa, e1b);
        x1_next.la = mulq(aa, e1a);
        x1_next.eb = sat36(sx36(e2b) - sx36(FX_ONE));
        x1_next.ea = sat36(sx36(e2a) - sx36(FX_ONE));
    end

    always_comb
    begin
        x2_next.here = x1_reg.here;
        x2_next.diff = x1_reg.diff;
        x2_next.vol = x1_reg.vol;
        x2_next.jb = mulq(x1_reg.lb, x1_reg.eb);
        x2_next.ja = mulq(x1_reg.la, x1_reg.ea);
    end

    always_comb
    begin
        x3_next.here = x2_reg.here;
        x3_next.val = sat36(36'sd0 - (sx36(x2_reg.diff) + sx36(x2_reg.vol)
                                      + sx36(x2_reg.jb) + sx36(x2_reg.ja)));
        x4_next.here = x3_reg.here;
        x4_next.val = sat36(sx36(x3_reg.val) - sx36(x3_reg.here));
        x5_next.here = x4_reg.here;
        x5_next.val = mulq(rg, x4_reg.val);
        x6_next.here = x5_reg.here;
        x6_next.val = sat36(sx36(x5_reg.here) + sx36(x5_reg.val));
    end

    logic signed [32:0] chg;
    logic [32:0]        chg_mag;

    always_comb
    begin
        chg = 33'(x6_reg.val) - 33'(x6_reg.here);
        chg_mag = chg[32] ? 33'(-chg) : 33'(chg);
        result_next.new_value = x6_reg.val;
        result_next.abs_change = (chg_mag > 33'h7FFFFFFF) ? 31'h7FFFFFFF : chg_mag[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            side_reg[0] <= '{here: s5_reg.here, diff: s5_reg.diff, vol: s5_reg.vol};
            for (int k = 1; k < EXP_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            x3_reg <= x3_next;
            x4_reg <= x4_next;
            x5_reg <= x5_next;
            x6_reg <= x6_next;
            result_reg <= result_next;
        end
    end

endmodule

/* tb/tb.sv */
// Self-checking testbench for hjb_stencil_relax_update: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb;
    import hsr_pkg::*;

    typedef struct {
        hsr_item_t   pt;
        bit          typed;
        hsr_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    hsr_item_t   item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    hsr_result_t result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;

    longint      reg_shadow [8];
    hsr_result_t pending_updates [$];
    int          error_count = 0;
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;
    int          stall_left = 0;
    stim_row_t   table_rows [$];

    hjb_stencil_relax_update DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #80_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        bit neg;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned q;
        longint unsigned lim;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        q = (ua * ub + 64'd32768) >> FRAC_W;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (q > lim)
            q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fx_exp(longint x);
        longint ln2;
        longint xg;
        longint n;
        longint r;
        longint s;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned val;
        ln2 = 64'sd744261118;
        if (x > 64'sd4194304)
            x = 64'sd4194304;
        if (x < -64'sd4194304)
            x = -64'sd4194304;
        xg = x * 16384;
        if (xg >= 0)
            n = xg / ln2;
        else
            n = -((-xg + ln2 - 1) / ln2);
        r = xg - n * ln2;
        term = 64'd1 << 30;
        sum = term;
        for (int i = 1; i <= 12; i++)
        begin
            term = ((term * longint'(r)) >> 30) / i;
            sum += term;
        end
        s = n + FRAC_W - 30;
        if (s >= 0)
        begin
            if (s >= 33)
                return 64'sd2147483647;
            val = sum << s;
        end
        else
        begin
            if (-s > 40)
                return 0;
            val = (sum + (64'd1 << (-s - 1))) >> (-s);
        end
        return (val > 64'd2147483647) ? 64'sd2147483647 : longint'(val);
    endfunction

    function automatic longint second_difference(longint up, longint mid, longint down);
        return clamp_word(up + down - mid - mid);
    endfunction

    function automatic longint clamp_jump_arg(longint v);
        if (v > 64'sd3276800)
            return 64'sd3276800;
        if (v < -64'sd3276800)
            return -64'sd3276800;
        return v;
    endfunction

    function automatic hsr_result_t relax_point(hsr_item_t pt);
        longint here;
        longint sigma;
        longint gam;
        longint kk;
        longint aa;
        longint cc;
        longint diffusion;
        longint volterm;
        longint dplus;
        longint dminus;
        longint db;
        longint da;
        longint lb;
        longint la;
        longint jb;
        longint ja;
        longint rhs;
        longint nv;
        longint ch;
        hsr_result_t res;
        here = longint'(pt.value_here);
        sigma = longint'(pt.vol_level);
        gam = reg_shadow[REG_RISK_AVERSION];
        kk = reg_shadow[REG_DECAY_RATE];
        aa = reg_shadow[REG_ARRIVAL_SCALE];
        cc = longint'(signed'(reg_shadow[REG_SPREAD_OFFSET][31:0]));
        diffusion = fx_mul(fx_mul(sigma, sigma), 64'sd32768);
        diffusion = fx_mul(diffusion, fx_mul(second_difference(longint'(pt.value_price_up),
            here, longint'(pt.value_price_down)), reg_shadow[REG_INV_PRICE_STEP_SQ]));
        volterm = fx_mul(reg_shadow[REG_HALF_VOLVOL_SQ], fx_mul(second_difference(
            longint'(pt.value_vol_up), here, longint'(pt.value_vol_down)),
            reg_shadow[REG_INV_VOL_STEP_SQ]));
        dplus = clamp_word(longint'(pt.value_inv_up) - here);
        dminus = clamp_word(here - longint'(pt.value_inv_down));
        db = clamp_word(cc + dplus);
        if (db > 64'sd655360)
            db = 64'sd655360;
        da = clamp_word(cc - dminus);
        if (da > 64'sd655360)
            da = 64'sd655360;
        lb = fx_mul(aa, fx_exp(clamp_word(-fx_mul(kk, db))));
        la = fx_mul(aa, fx_exp(clamp_word(-fx_mul(kk, da))));
        jb = fx_mul(lb, clamp_word(fx_exp(clamp_jump_arg(clamp_word(
            -fx_mul(gam, clamp_word(db + dplus))))) - 65536));
        ja = fx_mul(la, clamp_word(fx_exp(clamp_jump_arg(clamp_word(
            -fx_mul(gam, clamp_word(da - dminus))))) - 65536));
        rhs = clamp_word(-(diffusion + volterm + jb + ja));
        nv = clamp_word(here + fx_mul(reg_shadow[REG_RELAX_GAIN], clamp_word(rhs - here)));
        ch = nv - here;
        if (ch < 0)
            ch = -ch;
        if (ch > 64'sd2147483647)
            ch = 64'sd2147483647;
        res.new_value = nv[31:0];
        res.abs_change = ch[30:0];
        return res;
    endfunction

    function automatic longint unsigned reg_mask(logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_RELAX_GAIN: return 64'h1FFFF;
            REG_SPREAD_OFFSET: return 64'hFFFFFFFF;
            default: return 64'h7FFFFFFF;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_shadow[idx] = longint'(value) & reg_mask(idx);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);
    endtask

    task automatic send_point(hsr_item_t pt, bit typed, hsr_result_t want);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item <= pt;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        pending_updates.push_back(typed ? want : relax_point(pt));
        @(negedge clk);
    endtask

    task automatic end_burst();
        item_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word(int mode, logic [31:0] base);
        case (mode)
            0: return $urandom;
            1: return base + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    default: return $urandom;
                endcase
            end
            default: return base + 32'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
        endcase
    endfunction

    function automatic hsr_item_t random_point();
        hsr_item_t pt;
        int mode;
        mode = $urandom_range(0, 4);
        pt.value_here = (mode == 0 || mode == 2) ? $urandom
                                                 : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        pt.value_price_up = pick_word(mode, pt.value_here);
        pt.value_price_down = pick_word(mode, pt.value_here);
        pt.value_vol_up = pick_word(mode, pt.value_here);
        pt.value_vol_down = pick_word(mode, pt.value_here);
        pt.value_inv_up = pick_word(mode, pt.value_here);
        pt.value_inv_down = pick_word(mode, pt.value_here);
        pt.vol_level = ($urandom_range(0, 2) == 0) ? 22'($urandom) : 22'($urandom_range(0, 65536));
        return pt;
    endfunction

    function automatic logic [31:0] random_reg_value(logic [CFG_IDX_W-1:0] idx);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1 << 17);
            2: return $urandom_range(0, 1 << 12);
            default: return (idx == REG_RELAX_GAIN) ? 32'd65536 : $urandom_range(0, 1 << 20);
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (receiver_stalls && rst_n && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_updates.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %h %h", $realtime,
                         result.new_value, result.abs_change);
                error_count++;
            end
            else
            begin
                hsr_result_t want;
                want = pending_updates.pop_front();
                if (result.new_value !== want.new_value)
                begin
                    $display("%0t: new_value expected %h actual %h", $realtime,
                             want.new_value, result.new_value);
                    error_count++;
                end
                if (result.abs_change !== want.abs_change)
                begin
                    $display("%0t: abs_change expected %h actual %h", $realtime,
                             want.abs_change, result.abs_change);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        hsr_result_t none;
        stim_row_t   row;
        none = '0;
        reg_shadow[REG_RELAX_GAIN] = 32768;
        reg_shadow[REG_RISK_AVERSION] = 6554;
        reg_shadow[REG_DECAY_RATE] = 98304;
        reg_shadow[REG_ARRIVAL_SCALE] = 65536;
        reg_shadow[REG_SPREAD_OFFSET] = 42297;
        reg_shadow[REG_INV_PRICE_STEP_SQ] = 393380;
        reg_shadow[REG_INV_VOL_STEP_SQ] = 68044168;
        reg_shadow[REG_HALF_VOLVOL_SQ] = 328;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed points at the reset settings, checked by the predictor.
        row.typed = 1'b0;
        row.want = none;
        row.pt = '0;
        table_rows.push_back(row);
        row.pt = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 22'h3FFFFF};
        table_rows.push_back(row);
        row.pt = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 22'h0};
        table_rows.push_back(row);
        row.pt = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h80000000, 22'h3FFFFF};
        table_rows.push_back(row);
        row.pt = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h7FFFFFFF, 22'h10000};
        table_rows.push_back(row);
        row.pt = '{32'h00010000, 32'h00012000, 32'h0000F000, 32'h00010800, 32'h0000F800,
                   32'h00010400, 32'h0000FC00, 22'h03333};
        table_rows.push_back(row);
        // Both the bid and the ask offsets reach the cap of ten.
        row.pt = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00100000, 32'h00100000, 22'h8000};
        table_rows.push_back(row);
        // A large positive bid jump argument hits the upper clamp of the jump exponent.
        row.pt = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFF000000, 32'h01000000, 22'h8000};
        table_rows.push_back(row);
        foreach (table_rows[i])
            send_point(table_rows[i].pt, table_rows[i].typed, table_rows[i].want);
        end_burst();
        wait_drained();

        // With no risk aversion the jump terms vanish; with no gain the value holds.
        write_reg(REG_RISK_AVERSION, 32'd0);
        write_reg(REG_RELAX_GAIN, 32'd0);
        table_rows.delete();
        row.typed = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            row.pt = random_point();
            if (i == 0)
                row.pt.value_here = 32'h7FFFFFFF;
            if (i == 1)
                row.pt.value_here = 32'h80000000;
            row.want.new_value = row.pt.value_here;
            row.want.abs_change = '0;
            table_rows.push_back(row);
        end
        foreach (table_rows[i])
            send_point(table_rows[i].pt, table_rows[i].typed, table_rows[i].want);
        end_burst();
        wait_drained();

        for (int ph = 0; ph < 10; ph++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                if (ph == 0)
                    write_reg(CFG_IDX_W'(r), (r == REG_SPREAD_OFFSET) ? 32'h7FFFFFFF
                                 : (r == REG_RELAX_GAIN) ? 32'h1FFFF : 32'h7FFFFFFF);
                else if (ph == 1)
                    write_reg(CFG_IDX_W'(r), (r == REG_SPREAD_OFFSET) ? 32'h80000000 : 32'h0);
                else if (ph == 2)
                    write_reg(CFG_IDX_W'(r), (r == REG_RELAX_GAIN) ? 32'd65536
                                 : 32'($urandom_range(0, 200000)));
                else
                    write_reg(CFG_IDX_W'(r), random_reg_value(CFG_IDX_W'(r)));
            end
            if (ph == 9)
            begin
                sender_gaps = 1'b0;
                receiver_stalls = 1'b0;
            end
            for (int i = 0; i < 93; i++)
                send_point(random_point(), 1'b0, none);
            end_burst();
            wait_drained();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
